>>> rtl/trs_pkg.sv
// Package for the TRS model matrix builder: widths, CORDIC constants, payload types.
// No dependencies.
`timescale 1ns / 1ps
package trs_pkg;
  localparam int FracBits   = 16;
  localparam int CordSteps  = 16;
  localparam int TurnQ6     = 23040;
  localparam int HalfQ6     = 11520;
  localparam int QuarterQ6  = 5760;
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } xform_t;

  typedef struct packed {
    logic [1:0]         column_index;
    logic signed [31:0] elem_x;
    logic signed [31:0] elem_y;
    logic signed [31:0] elem_z;
    logic signed [31:0] elem_w;
    logic               last_column;
  } column_t;

  function automatic logic signed [24:0] atan_q16(input logic [3:0] i);
    case (i)
      4'd0: atan_q16 = 25'sd2949120;  4'd1: atan_q16 = 25'sd1740967;
      4'd2: atan_q16 = 25'sd919879;   4'd3: atan_q16 = 25'sd466945;
      4'd4: atan_q16 = 25'sd234379;   4'd5: atan_q16 = 25'sd117304;
      4'd6: atan_q16 = 25'sd58666;    4'd7: atan_q16 = 25'sd29335;
      4'd8: atan_q16 = 25'sd14668;    4'd9: atan_q16 = 25'sd7334;
      4'd10: atan_q16 = 25'sd3667;    4'd11: atan_q16 = 25'sd1833;
      4'd12: atan_q16 = 25'sd917;     4'd13: atan_q16 = 25'sd458;
      4'd14: atan_q16 = 25'sd229;     default: atan_q16 = 25'sd115;
    endcase
  endfunction

  // Q2.30 product with round-half-up, result kept at 36 bits.
  function automatic logic signed [35:0] mul_q30(input logic signed [33:0] a,
                                                  input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b + 68'sd536870912;
    mul_q30 = p[65:30];
  endfunction
endpackage

>>> rtl/trs_if.sv
// Valid/ready channel interface carrying one payload word.
// No dependencies; the payload type is a parameter.
`timescale 1ns / 1ps
interface trs_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/trs_model_matrix.sv
// An accepted transform passes through all pipe stages before its column 0 is offered;
// the other columns follow one per cycle while the output is ready.
// Each transform leaves as four column words on the single output column channel.
// The pipe (1 reduce + 16 CORDIC stages + 3 product stages + 2 hold stages) advances
// while the tail is empty or hands over its last column; otherwise all stages hold.
// Reset clears the valid bits and the column counter; payload registers are not reset.
// Depends on trs_pkg and trs_if.
`timescale 1ns / 1ps
module trs_model_matrix
  import trs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  trs_if.sink   in_i,
  trs_if.source out_o
);
  localparam int NS = 22;

  typedef struct packed {
    logic signed [33:0] x, y;
    logic signed [26:0] z;
    logic               neg;
  } cord_t;

  logic [NS-1:0] v_q;
  logic          adv;
  logic [1:0]    col_q;
  logic          emit;

  // Stall the whole chain whenever the tail word cannot move.
  assign adv = !v_q[NS-1] || emit;
  assign in_i.ready = adv;

  // Payload carried through the pipe.
  xform_t        xf_q [NS];
  cord_t         cq_q [3][17];

  // Angle reduce to [-90,90] deg, cosine sign flag.
  function automatic cord_t reduce(input logic signed [15:0] a);
    logic signed [16:0] r;
    cord_t c;
    // one turn spans more than a third of the input range, so one add or subtract wraps it
    r = 17'(a);
    if (r >= 17'sd11520) r = r - 17'sd23040;
    else if (r < -17'sd11520) r = r + 17'sd23040;
    c.neg = 1'b0;
    if (r > 17'sd5760) begin
      r = 17'sd11520 - r; c.neg = 1'b1;
    end else if (r < -17'sd5760) begin
      r = -17'sd11520 - r; c.neg = 1'b1;
    end
    c.x = GainQ30;
    c.y = '0;
    c.z = 27'(r) <<< 10;
    return c;
  endfunction

  function automatic cord_t cstep(input cord_t c, input logic [3:0] i);
    cord_t o;
    logic signed [33:0] dx, dy;
    dx = c.y >>> i;
    dy = c.x >>> i;
    o = c;
    if (c.z >= 0) begin
      o.x = c.x - dx; o.y = c.y + dy; o.z = c.z - 27'(atan_q16(i));
    end else begin
      o.x = c.x + dx; o.y = c.y - dy; o.z = c.z + 27'(atan_q16(i));
    end
    return o;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[NS-2:0], in_i.valid};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xf_q[0] <= in_i.data;
      for (int k = 1; k < NS; k++) xf_q[k] <= xf_q[k-1];
      cq_q[0][0] <= reduce(in_i.data.angle_x);
      cq_q[1][0] <= reduce(in_i.data.angle_y);
      cq_q[2][0] <= reduce(in_i.data.angle_z);
      for (int a = 0; a < 3; a++)
        for (int k = 1; k < 17; k++) cq_q[a][k] <= cstep(cq_q[a][k-1], 4'(k-1));
    end
  end

  // Sine/cosine at stage 17 (index 16).
  logic signed [33:0] sx, cx, sy, cy, sz, cz;
  always_comb begin
    sx = cq_q[0][16].y; cx = cq_q[0][16].neg ? -cq_q[0][16].x : cq_q[0][16].x;
    sy = cq_q[1][16].y; cy = cq_q[1][16].neg ? -cq_q[1][16].x : cq_q[1][16].x;
    sz = cq_q[2][16].y; cz = cq_q[2][16].neg ? -cq_q[2][16].x : cq_q[2][16].x;
  end

  // Stage A: first-level products.
  logic signed [33:0] sysx_q, cysx_q, sx_q, cx_q, sy_q, cy_q, sz_q, cz_q;
  // Stage B: rotation entries.
  logic signed [35:0] rot_q [9];
  // Stage C: scaled and saturated entries.
  logic signed [31:0] ent_q [9];

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] scl(input logic signed [35:0] r,
                                             input logic signed [31:0] s);
    logic signed [67:0] p;
    p = r * s + 68'sd536870912;
    return sat32(66'(p >>> 30));
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sysx_q <= 34'(mul_q30(sy, sx));
      cysx_q <= 34'(mul_q30(cy, sx));
      sx_q <= sx; cx_q <= cx; sy_q <= sy; cy_q <= cy; sz_q <= sz; cz_q <= cz;
      rot_q[0] <= mul_q30(cy_q, cz_q) + mul_q30(sysx_q, sz_q);
      rot_q[1] <= mul_q30(sysx_q, cz_q) - mul_q30(cy_q, sz_q);
      rot_q[2] <= mul_q30(sy_q, cx_q);
      rot_q[3] <= mul_q30(cx_q, sz_q);
      rot_q[4] <= mul_q30(cx_q, cz_q);
      rot_q[5] <= -36'(sx_q);
      rot_q[6] <= mul_q30(cysx_q, sz_q) - mul_q30(sy_q, cz_q);
      rot_q[7] <= mul_q30(sy_q, sz_q) + mul_q30(cysx_q, cz_q);
      rot_q[8] <= mul_q30(cy_q, cx_q);
      for (int r = 0; r < 3; r++) begin
        ent_q[3*r+0] <= scl(rot_q[3*r+0], xf_q[18].scale_x);
        ent_q[3*r+1] <= scl(rot_q[3*r+1], xf_q[18].scale_y);
        ent_q[3*r+2] <= scl(rot_q[3*r+2], xf_q[18].scale_z);
      end
    end
  end
  // Pipeline: cq[16] valid at v_q[16]; A at 17; B at 18; C at 19... pad to NS-1.
  // ent_q is loaded from stage 18 data, so entries align with v_q[19]; hold through tail.
  logic signed [31:0] hold_q [9];
  logic signed [31:0] hold2_q [9];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      hold_q  <= ent_q;
      hold2_q <= hold_q;
    end
  end

  // Serialize tail word into four columns.
  xform_t   t;
  column_t  w;
  assign t = xf_q[NS-1];
  always_comb begin
    w.column_index = col_q;
    w.last_column  = (col_q == 2'd3);
    w.elem_w       = (col_q == 2'd3) ? 32'sd1 <<< FracBits : '0;
    case (col_q)
      2'd3: begin
        w.elem_x = t.pos_x; w.elem_y = t.pos_y; w.elem_z = t.pos_z;
      end
      default: begin
        w.elem_x = hold2_q[{2'b00, col_q}];
        w.elem_y = hold2_q[4'd3 + {2'b00, col_q}];
        w.elem_z = hold2_q[4'd6 + {2'b00, col_q}];
      end
    endcase
  end

  assign out_o.valid = v_q[NS-1];
  assign out_o.data  = w;
  assign emit = v_q[NS-1] && out_o.ready && (col_q == 2'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) col_q <= '0;
    else if (v_q[NS-1] && out_o.ready) col_q <= col_q + 2'd1;
  end
endmodule

>>> sim/trs_model_matrix_tb.sv
// Self-checking testbench for trs_model_matrix: directed table, then random transforms.
// Depends on trs_pkg, trs_if and trs_model_matrix from the RTL.
`timescale 1ns / 1ps
module trs_model_matrix_tb;
  import trs_pkg::*;

  localparam int      NumRandom = 154;
  localparam int      CycleLimit = 200000;
  localparam int      DrainCycles = 40;
  localparam longint  Half30 = 64'sd536870912;
  localparam longint  One16 = 64'sd65536;

  // atan(2^-i) in degrees, Q16
  localparam longint ArcDeg [CordSteps] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  typedef struct {
    xform_t  xf;
    bit      typed;     // column 3 typed in below instead of predicted
    column_t col3;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  trs_if #(.T(xform_t))  in_ch ();
  trs_if #(.T(column_t)) out_ch ();

  trs_model_matrix i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #10 clk_i = ~clk_i;

  column_t   pending_cols [$];
  int        err_cnt = 0;
  int        col_cnt = 0;
  int        xf_cnt = 0;
  int        stall_left = 0;
  bit        quiet = 1'b0;     // no idling near the end of the run
  int        cycle_cnt = 0;
  stim_row_t rows [$];

  // Q2.30 product, rounded half up with a floor shift
  function automatic longint q30_mul(longint a, longint b);
    return (a * b + Half30) >>> 30;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Reduce to one turn, fold into [-90,90], then run the CORDIC.
  task automatic angle_sincos(input logic signed [15:0] ang, output longint s,
                              output longint c);
    longint r, x, y, z, dx, dy;
    bit     flip;
    r = longint'(ang) % TurnQ6;
    flip = 1'b0;
    x = GainQ30;
    y = 0;
    if (r < 0) r += TurnQ6;
    if (r >= HalfQ6) r -= TurnQ6;
    if (r > QuarterQ6) begin
      r = HalfQ6 - r;
      flip = 1'b1;
    end else if (r < -QuarterQ6) begin
      r = -HalfQ6 - r;
      flip = 1'b1;
    end
    z = r * 1024;
    for (int i = 0; i < CordSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ArcDeg[i];
      end else begin
        x += dx; y -= dy; z += ArcDeg[i];
      end
    end
    s = y;
    c = flip ? -x : x;
  endtask

  // Build the four columns of T * Ry * Rx * Rz * S and queue them.
  task automatic queue_model_matrix(input xform_t t);
    longint  sx, cx, sy, cy, sz, cz, sysx, cysx;
    longint  rot [3][3];
    longint  scl [3];
    longint  pos [3];
    column_t col;
    angle_sincos(t.angle_x, sx, cx);
    angle_sincos(t.angle_y, sy, cy);
    angle_sincos(t.angle_z, sz, cz);
    scl = '{longint'(t.scale_x), longint'(t.scale_y), longint'(t.scale_z)};
    pos = '{longint'(t.pos_x), longint'(t.pos_y), longint'(t.pos_z)};
    sysx = q30_mul(sy, sx);
    cysx = q30_mul(cy, sx);
    rot[0][0] = q30_mul(cy, cz) + q30_mul(sysx, sz);
    rot[0][1] = q30_mul(sysx, cz) - q30_mul(cy, sz);
    rot[0][2] = q30_mul(sy, cx);
    rot[1][0] = q30_mul(cx, sz);
    rot[1][1] = q30_mul(cx, cz);
    rot[1][2] = -sx;
    rot[2][0] = q30_mul(cysx, sz) - q30_mul(sy, cz);
    rot[2][1] = q30_mul(sy, sz) + q30_mul(cysx, cz);
    rot[2][2] = q30_mul(cy, cx);
    for (int c = 0; c < 3; c++) begin
      col.column_index = 2'(c);
      col.elem_x = 32'(clamp32(q30_mul(rot[0][c], scl[c])));
      col.elem_y = 32'(clamp32(q30_mul(rot[1][c], scl[c])));
      col.elem_z = 32'(clamp32(q30_mul(rot[2][c], scl[c])));
      col.elem_w = '0;
      col.last_column = 1'b0;
      pending_cols.insert(pending_cols.size(), col);
    end
    col.column_index = 2'd3;
    col.elem_x = 32'(pos[0]);
    col.elem_y = 32'(pos[1]);
    col.elem_z = 32'(pos[2]);
    col.elem_w = 32'(One16);
    col.last_column = 1'b1;
    pending_cols.insert(pending_cols.size(), col);
  endtask

  function automatic xform_t mk(int px, int py, int pz, int ax, int ay, int az,
                                int kx, int ky, int kz);
    xform_t t;
    t = '{32'(px), 32'(py), 32'(pz), 16'(ax), 16'(ay), 16'(az), 32'(kx), 32'(ky), 32'(kz)};
    return t;
  endfunction

  function automatic stim_row_t row(xform_t t, bit typed);
    stim_row_t r;
    r.xf = t;
    r.typed = typed;
    // position passes through; row 3 is one in Q16.16
    r.col3 = '{2'd3, t.pos_x, t.pos_y, t.pos_z, 32'h0001_0000, 1'b1};
    return r;
  endfunction

  // Append one row to the directed table.
  task automatic add_row(input stim_row_t r);
    rows.insert(rows.size(), r);
  endtask

  // Hold the word until the block takes it, with an optional idle burst first.
  task automatic send_xform(input xform_t t, input stim_row_t r, input bit use_row);
    if (!quiet && ($urandom_range(0, 3) == 0)) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_ch.data  <= t;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    queue_model_matrix(t);
    if (use_row && r.typed) begin
      void'(pending_cols.pop_back());
      pending_cols.insert(pending_cols.size(), r.col3);
    end
    xf_cnt++;
  endtask

  function automatic xform_t rand_xform();
    xform_t t;
    t.pos_x = $urandom; t.pos_y = $urandom; t.pos_z = $urandom;
    if ($urandom_range(0, 4) < 3) begin
      // mostly ordinary scenes: angles within one turn either way, scales within +-4.0
      t.angle_x = 16'($urandom_range(0, 46080) - 23040);
      t.angle_y = 16'($urandom_range(0, 46080) - 23040);
      t.angle_z = 16'($urandom_range(0, 46080) - 23040);
      t.scale_x = 32'($urandom_range(0, 524288) - 262144);
      t.scale_y = 32'($urandom_range(0, 524288) - 262144);
      t.scale_z = 32'($urandom_range(0, 524288) - 262144);
    end else begin
      t.angle_x = 16'($urandom); t.angle_y = 16'($urandom); t.angle_z = 16'($urandom);
      t.scale_x = $urandom; t.scale_y = $urandom; t.scale_z = $urandom;
    end
    return t;
  endfunction

  // Sink side: compare each accepted word, then pick the next ready value.
  always @(posedge clk_i) begin
    column_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      col_cnt++;
      if (pending_cols.size() == 0) begin
        $error("column word with nothing expected: col %0d", got.column_index);
        err_cnt++;
      end else begin
        want = pending_cols.pop_front();
        if (got.column_index !== want.column_index) begin
          $error("column_index exp %0d got %0d", want.column_index, got.column_index);
          err_cnt++;
        end
        if (got.elem_x !== want.elem_x) begin
          $error("elem_x exp %h got %h", want.elem_x, got.elem_x);
          err_cnt++;
        end
        if (got.elem_y !== want.elem_y) begin
          $error("elem_y exp %h got %h", want.elem_y, got.elem_y);
          err_cnt++;
        end
        if (got.elem_z !== want.elem_z) begin
          $error("elem_z exp %h got %h", want.elem_z, got.elem_z);
          err_cnt++;
        end
        if (got.elem_w !== want.elem_w) begin
          $error("elem_w exp %h got %h", want.elem_w, got.elem_w);
          err_cnt++;
        end
        if (got.last_column !== want.last_column) begin
          $error("last_column exp %0b got %0b", want.last_column, got.last_column);
          err_cnt++;
        end
      end
    end
    if (quiet) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 17) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d columns outstanding", cycle_cnt,
               pending_cols.size());
      $display("trs_model_matrix_tb: FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t blank;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    blank = row('0, 1'b0);

    // Directed table: extremes, fold boundaries, turn wrap, saturation.
    add_row(row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1));
    add_row(row(mk(32'h7fffffff, 32'h80000000, 1, 0, 0, 0,
                   65536, 65536, 65536), 1'b1));
    add_row(row(mk(-1, 32'h80000000, 32'h7fffffff, 5760, 0, 0,
                   65536, 65536, 65536), 1'b1));
    add_row(row(mk(65536, 0, 0, 0, 5760, 0, 65536, 65536, 65536), 1'b0));
    add_row(row(mk(0, 65536, 0, 0, 0, 5760, 65536, 65536, 65536), 1'b0));
    add_row(row(mk(0, 0, 0, -5760, -5760, -5760, 65536, 65536, 65536), 1'b0));
    // just past a quarter turn: folded with cosine negated
    add_row(row(mk(0, 0, 0, 5761, -5761, 5761, 65536, 65536, 65536), 1'b0));
    add_row(row(mk(0, 0, 0, 11520, -11520, 11519, 65536, 65536, 65536), 1'b0));
    add_row(row(mk(0, 0, 0, 17280, -17280, 23039, 65536, 65536, 65536), 1'b0));
    // whole turns and beyond wrap back
    add_row(row(mk(0, 0, 0, 23040, -23040, 46080, 65536, 65536, 65536), 1'b0));
    add_row(row(mk(0, 0, 0, 32767, -32768, 32767, 65536, 65536, 65536), 1'b0));
    add_row(row(mk(0, 0, 0, -32768, 32767, -32768, 65536, 65536, 65536), 1'b0));
    // scaled entries driven to the rails
    add_row(row(mk(0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff),
                1'b0));
    add_row(row(mk(0, 0, 0, 2880, 2880, 2880,
                   32'h7fffffff, 32'h7fffffff, 32'h80000000), 1'b0));
    add_row(row(mk(0, 0, 0, 11520, 11520, 11520,
                   32'h80000000, 32'h80000000, 32'h80000000), 1'b0));
    add_row(row(mk(32'h12345678, 32'hedcba987, 32'h55aa55aa, 1920, -3840, 8000,
                   -131072, 98304, 32768), 1'b0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_xform(rows[i].xf, rows[i], 1'b1);
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom - 30) quiet = 1'b1;
      send_xform(rand_xform(), blank, 1'b0);
    end
    in_ch.valid <= 1'b0;

    while (pending_cols.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d transforms (fold, wrap and saturation corners included)", xf_cnt);
    $display("checked %0d column words, %0d mismatches", col_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("trs_model_matrix_tb: PASS");
    end else begin
      $display("trs_model_matrix_tb: FAIL");
    end
    $finish;
  end
endmodule
